// ----- rtl/alut_pkg.sv -----
// ----------------------------------------------------------------------------
// alut_pkg
// Shared types and constants for the adjacency link table upsert block.
// ----------------------------------------------------------------------------
package alut_pkg;

  localparam int NODES_DEF = 1024;
  localparam int LINKS_DEF = 16;
  localparam int VERTS_DEF = 16;

  localparam int NODE_W   = 16;
  localparam int EDGE_W   = 8;
  localparam int HEIGHT_W = 16;
  localparam int FLAGS_W  = 8;

  localparam int IN_W  = 72;
  localparam int OUT_W = 16;

  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_BAD_NODE = 3'd2,
    ST_BAD_EDGE = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_COUNT,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } mem_ctl_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]  flags;
    logic [HEIGHT_W-1:0] height;
    logic [EDGE_W-1:0]   dst_edge;
    logic [EDGE_W-1:0]   src_edge;
  } link_data_t;

endpackage

// ----- rtl/alut_links.sv -----
// ----------------------------------------------------------------------------
// alut_links
// Single-port link slot memory, one row of LINKS slots per node; registered
// read of the stored target node.
// ----------------------------------------------------------------------------
module alut_links #(
  parameter int  NODES = alut_pkg::NODES_DEF,
  parameter int  LINKS = alut_pkg::LINKS_DEF,
  localparam int NW    = $clog2(NODES),
  localparam int SW    = (LINKS > 1) ? $clog2(LINKS) : 1
) (
  input  logic                 clk,
  input  alut_pkg::mem_ctl_t   ctl,
  input  logic [NW-1:0]        node,
  input  logic [SW-1:0]        slot,
  input  logic [NW-1:0]        target,
  input  alut_pkg::link_data_t wdata,
  output logic [NW-1:0]        rd_target
);

  localparam int AW    = NW + SW;
  localparam int DEPTH = NODES << SW;
  localparam int DW    = NW + $bits(alut_pkg::link_data_t);

  logic [DW-1:0] link_mem [DEPTH];
  logic [AW-1:0] addr;

  assign addr = {node, slot};

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      link_mem[addr] <= {target, wdata};
    end
    if (ctl.rd) begin
      rd_target <= link_mem[addr][DW-1 -: NW];
    end
  end

endmodule

// ----- rtl/adjacency_link_table_upsert_top.sv -----
// ----------------------------------------------------------------------------
// adjacency_link_table_upsert_top
// Per-node adjacency table: update the link to a target or insert a new one.
// ----------------------------------------------------------------------------
// Usage:
//   One request on the s_ channel asks to add a link from one node to
//   another; exactly one result follows on the m_ channel with a status,
//   the slot written and the source node's link count.
//   A bad node goes straight to the result, a bad edge right after the
//   count read; otherwise the scan covers at most the source node's
//   count of filled slots (fewer when an update hits an early slot).
//   The scan reads one slot per cycle from the single-port link memory,
//   pipelined against the target compare.
//   The block takes one request at a time; s_tready is high only while it
//   waits for a request, also while a previous result is still held.
//   A stalled m_ side holds the result register and blocks the next
//   result only.
//   After reset the per-node count memory is swept to zero, one node per
//   cycle; s_tready stays low during that sweep.
//   Slots of a node fill in order, so the count alone marks which slots
//   are valid and the link memory needs no clearing.
// ----------------------------------------------------------------------------
module adjacency_link_table_upsert_top #(
  parameter int NODES = alut_pkg::NODES_DEF,
  parameter int LINKS = alut_pkg::LINKS_DEF,
  parameter int VERTS = alut_pkg::VERTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // from_node[15:0], to_node[31:16], src_edge[39:32], dst_edge[47:40],
  // height_diff[63:48], link_flags[71:64]
  input  logic [alut_pkg::IN_W-1:0] s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[2:0], slot_used[6:3], link_count[11:7], zero[15:12]
  output logic [alut_pkg::OUT_W-1:0] m_tdata
);

  localparam int NW = $clog2(NODES);
  localparam int SW = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int CW = $clog2(LINKS + 1);

  alut_pkg::state_t     state, state_next;
  alut_pkg::mem_ctl_t   lk_ctl;
  alut_pkg::link_data_t wdata;
  alut_pkg::status_t    res_status;

  logic [NW-1:0] clr_idx;
  logic [NW-1:0] from_q, to_q;
  logic [NW-1:0] rd_target;
  logic [SW-1:0] lk_slot;
  logic [SW-1:0] pend_slot;
  logic [SW-1:0] res_slot;
  logic [CW-1:0] count_mem [NODES];
  logic [CW-1:0] cnt_rd, cnt, rd_slot, res_count;
  logic [CW-1:0] cnt_wdata;
  logic [NW-1:0] cnt_waddr;
  logic          cnt_we;
  logic          pend;
  logic          accept;
  logic          out_free;
  logic          from_ok, to_ok, src_ok, dst_ok;
  logic          edge_bad_q;
  logic          hit, issue, full;
  logic [31:0]   slot_ext, count_ext;

  logic signed [alut_pkg::NODE_W-1:0] in_from, in_to;
  logic signed [alut_pkg::EDGE_W-1:0] in_src, in_dst;

  assign in_from = s_tdata[15:0];
  assign in_to   = s_tdata[31:16];
  assign in_src  = s_tdata[39:32];
  assign in_dst  = s_tdata[47:40];

  assign from_ok = !in_from[15] && (32'(in_from[14:0]) < NODES);
  assign to_ok   = !in_to[15] && (32'(in_to[14:0]) < NODES);
  assign src_ok  = !in_src[7] && (32'(in_src[6:0]) < VERTS);
  assign dst_ok  = !in_dst[7] && (32'(in_dst[6:0]) < VERTS);

  assign s_tready = (state == alut_pkg::S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign hit   = pend && (rd_target == to_q);
  assign issue = !hit && (rd_slot < cnt);
  assign full  = (cnt == CW'(LINKS));

  assign slot_ext  = 32'(res_slot);
  assign count_ext = 32'(res_count);

  // next state and memory controls
  always_comb begin
    state_next = state;
    lk_ctl     = '0;
    lk_slot    = rd_slot[SW-1:0];
    cnt_we     = 1'b0;
    cnt_waddr  = from_q;
    cnt_wdata  = cnt + CW'(1);
    case (state)
      alut_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_idx;
        cnt_wdata = '0;
        if (clr_idx == NW'(NODES - 1)) begin
          state_next = alut_pkg::S_IDLE;
        end
      end
      alut_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (from_ok && to_ok) ? alut_pkg::S_COUNT : alut_pkg::S_DONE;
        end
      end
      alut_pkg::S_COUNT: begin
        state_next = edge_bad_q ? alut_pkg::S_DONE : alut_pkg::S_SCAN;
      end
      alut_pkg::S_SCAN: begin
        if (hit) begin
          lk_ctl.wr  = 1'b1;
          lk_slot    = pend_slot;
          state_next = alut_pkg::S_DONE;
        end else if (issue) begin
          lk_ctl.rd = 1'b1;
        end else begin
          if (!full) begin
            lk_ctl.wr = 1'b1;
            lk_slot   = cnt[SW-1:0];
            cnt_we    = 1'b1;
          end
          state_next = alut_pkg::S_DONE;
        end
      end
      alut_pkg::S_DONE: begin
        if (out_free) begin
          state_next = alut_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = alut_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= alut_pkg::S_CLEAR;
      clr_idx  <= '0;
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == alut_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + NW'(1);
      end
      if (state == alut_pkg::S_SCAN) begin
        pend <= issue;
      end else begin
        pend <= 1'b0;
      end
      if (state == alut_pkg::S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request fields, scan pointer and result
  always_ff @(posedge clk) begin
    case (state)
      alut_pkg::S_IDLE: begin
        if (accept) begin
          from_q     <= s_tdata[NW-1:0];
          to_q       <= s_tdata[16 +: NW];
          wdata      <= s_tdata[71:32];
          edge_bad_q <= !(src_ok && dst_ok);
          res_status <= alut_pkg::ST_BAD_NODE;
          res_slot   <= '0;
          res_count  <= '0;
        end
      end
      alut_pkg::S_COUNT: begin
        cnt        <= cnt_rd;
        rd_slot    <= '0;
        res_status <= alut_pkg::ST_BAD_EDGE;
        res_slot   <= '0;
        res_count  <= cnt_rd;
      end
      alut_pkg::S_SCAN: begin
        if (hit) begin
          res_status <= alut_pkg::ST_UPDATED;
          res_slot   <= pend_slot;
          res_count  <= cnt;
        end else if (issue) begin
          pend_slot <= rd_slot[SW-1:0];
          rd_slot   <= rd_slot + CW'(1);
        end else if (full) begin
          res_status <= alut_pkg::ST_FULL;
          res_slot   <= '0;
          res_count  <= cnt;
        end else begin
          res_status <= alut_pkg::ST_INSERTED;
          res_slot   <= cnt[SW-1:0];
          res_count  <= cnt + CW'(1);
        end
      end
      alut_pkg::S_DONE: begin
        if (out_free) begin
          m_tdata <= {4'd0, count_ext[4:0], slot_ext[3:0], res_status};
        end
      end
      default: begin
      end
    endcase
  end

  // per-node filled count memory
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      count_mem[cnt_waddr] <= cnt_wdata;
    end
    if (accept) begin
      cnt_rd <= count_mem[s_tdata[NW-1:0]];
    end
  end

  alut_links #(
    .NODES(NODES),
    .LINKS(LINKS)
  ) u_links (
    .clk      (clk),
    .ctl      (lk_ctl),
    .node     (from_q),
    .slot     (lk_slot),
    .target   (to_q),
    .wdata    (wdata),
    .rd_target(rd_target)
  );

`ifndef ASSERT_OFF
  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == alut_pkg::S_COUNT || state == alut_pkg::S_DONE))
    else $error("accepted request did not start count read or result");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == alut_pkg::S_SCAN |-> (rd_slot <= cnt && cnt <= CW'(LINKS)))
    else $error("scan pointer or count out of range");

  a_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (lk_ctl.wr || (cnt_we && state != alut_pkg::S_CLEAR)) |-> state == alut_pkg::S_SCAN)
    else $error("table write outside scan");

  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(lk_ctl.wr && lk_ctl.rd))
    else $error("link memory read and write in one cycle");
`endif

endmodule

// ----- tb/alut_link_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alut_link_checker
// Watches the request and reply channels of the adjacency link table,
// keeps its own copy of every node's link targets and counts, works out
// the reply for each accepted request and compares the replies in order.
// ----------------------------------------------------------------------------
module alut_link_checker #(
  parameter int NODES = alut_pkg::NODES_DEF,
  parameter int LINKS = alut_pkg::LINKS_DEF,
  parameter int VERTS = alut_pkg::VERTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [alut_pkg::IN_W-1:0]  s_tdata,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [alut_pkg::OUT_W-1:0] m_tdata,
  output int                         mismatches,
  output int                         outstanding,
  output int                         n_updated,
  output int                         n_inserted,
  output int                         n_bad_node,
  output int                         n_bad_edge,
  output int                         n_full
);

  typedef struct packed {
    alut_pkg::status_t            status;
    logic [alut_pkg::SLOT_W-1:0]  slot;
    logic [alut_pkg::COUNT_W-1:0] count;
  } reply_t;

  logic [alut_pkg::NODE_W-1:0] target_of [NODES][LINKS];
  int                          links_in [NODES];
  reply_t                      replies_due [$];
  int                          errs;

  function automatic reply_t upsert_outcome(input logic [alut_pkg::IN_W-1:0] req);
    logic signed [alut_pkg::NODE_W-1:0] from_n;
    logic signed [alut_pkg::NODE_W-1:0] to_n;
    logic signed [alut_pkg::EDGE_W-1:0] src_e;
    logic signed [alut_pkg::EDGE_W-1:0] dst_e;
    reply_t                             r;
    int                                 fi;
    int                                 hit;
    from_n = req[15:0];
    to_n   = req[31:16];
    src_e  = req[39:32];
    dst_e  = req[47:40];
    r.status = alut_pkg::ST_BAD_NODE;
    r.slot   = '0;
    r.count  = '0;
    if (from_n < 0 || from_n >= NODES || to_n < 0 || to_n >= NODES) return r;
    fi = int'(from_n);
    r.count = alut_pkg::COUNT_W'(links_in[fi]);
    if (src_e < 0 || src_e >= VERTS || dst_e < 0 || dst_e >= VERTS) begin
      r.status = alut_pkg::ST_BAD_EDGE;
      return r;
    end
    hit = -1;
    for (int i = 0; i < links_in[fi]; i++) begin
      if (hit < 0 && target_of[fi][i] == to_n) hit = i;
    end
    if (hit >= 0) begin
      r.status = alut_pkg::ST_UPDATED;
      r.slot   = alut_pkg::SLOT_W'(hit);
    end else if (links_in[fi] < LINKS) begin
      target_of[fi][links_in[fi]] = to_n;
      r.status = alut_pkg::ST_INSERTED;
      r.slot   = alut_pkg::SLOT_W'(links_in[fi]);
      links_in[fi]++;
      r.count  = alut_pkg::COUNT_W'(links_in[fi]);
    end else begin
      r.status = alut_pkg::ST_FULL;
    end
    return r;
  endfunction

  task automatic report_bad(input string what, input reply_t want,
                            input logic [alut_pkg::OUT_W-1:0] got);
    errs++;
    if (errs <= 10)
      $display({"%0t: %s: expected status %0d slot %0d count %0d, ",
                "got status %0d slot %0d count %0d pad %h"},
               $time, what, want.status, want.slot, want.count,
               got[2:0], got[6:3], got[11:7], got[15:12]);
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t fresh;
    if (rst) begin
      for (int n = 0; n < NODES; n++) links_in[n] = 0;
      replies_due.delete();
      errs = 0;
      n_updated = 0;
      n_inserted = 0;
      n_bad_node = 0;
      n_bad_edge = 0;
      n_full = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (replies_due.size() == 0) begin
          want = '0;
          report_bad("reply with no request pending", want, m_tdata);
        end else begin
          want = replies_due.pop_front();
          if (m_tdata[2:0] !== want.status || m_tdata[6:3] !== want.slot ||
              m_tdata[11:7] !== want.count || m_tdata[15:12] !== 4'd0)
            report_bad("reply mismatch", want, m_tdata);
        end
      end
      if (s_tvalid && s_tready) begin
        fresh = upsert_outcome(s_tdata);
        replies_due.insert(replies_due.size(), fresh);
        case (fresh.status)
          alut_pkg::ST_UPDATED:  n_updated++;
          alut_pkg::ST_INSERTED: n_inserted++;
          alut_pkg::ST_BAD_NODE: n_bad_node++;
          alut_pkg::ST_BAD_EDGE: n_bad_edge++;
          default:               n_full++;
        endcase
      end
    end
    outstanding <= replies_due.size();
    mismatches  <= errs;
  end

endmodule

// ----- tb/tb_adjacency_link_table_upsert_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adjacency_link_table_upsert_top
// Drives link requests into the adjacency link table in random bursts,
// starting with fill, full, update, self-link and range-error cases, then
// random traffic over a node pool that fills up; the reply side stalls on
// its own pattern, once for a long stretch. A checker predicts each reply.
// ----------------------------------------------------------------------------
module tb_adjacency_link_table_upsert_top;

  localparam int NODES       = alut_pkg::NODES_DEF;
  localparam int LINKS       = alut_pkg::LINKS_DEF;
  localparam int VERTS       = alut_pkg::VERTS_DEF;
  localparam int RANDOM_REQS = 1125;
  localparam int HOLD_AT     = 3000;
  localparam int HOLD_LEN    = 600;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [alut_pkg::IN_W-1:0]  s_tdata;
  logic                       m_tvalid;
  logic                       m_tready;
  logic [alut_pkg::OUT_W-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int n_updated;
  int n_inserted;
  int n_bad_node;
  int n_bad_edge;
  int n_full;
  int burst_left;
  int sent;

  adjacency_link_table_upsert_top #(
    .NODES(NODES),
    .LINKS(LINKS),
    .VERTS(VERTS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  alut_link_checker #(
    .NODES(NODES),
    .LINKS(LINKS),
    .VERTS(VERTS)
  ) link_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .n_updated   (n_updated),
    .n_inserted  (n_inserted),
    .n_bad_node  (n_bad_node),
    .n_bad_edge  (n_bad_edge),
    .n_full      (n_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("adjacency_link_table_upsert_top regression: fail");
    $finish;
  end

  function automatic logic [alut_pkg::IN_W-1:0] link_req(input int from_n, input int to_n,
                                                         input int src, input int dst,
                                                         input int height,
                                                         input int flags);
    return {flags[7:0], height[15:0], dst[7:0], src[7:0], to_n[15:0], from_n[15:0]};
  endfunction

  function automatic logic [alut_pkg::IN_W-1:0] random_req();
    int pick;
    int from_n;
    int to_n;
    pick   = $urandom_range(0, 99);
    from_n = $urandom_range(0, 31) * 33;
    to_n   = $urandom_range(0, 1) ? $urandom_range(0, 23) * 41
                                  : $urandom_range(0, NODES - 1);
    if (pick < 75)
      return link_req(from_n, to_n, $urandom_range(0, VERTS - 1),
                      $urandom_range(0, VERTS - 1), $urandom, $urandom);
    if (pick < 87)
      return link_req(from_n, to_n, $urandom, $urandom, $urandom, $urandom);
    return link_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic offer(input logic [alut_pkg::IN_W-1:0] req);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= req;
    do @(posedge clk); while (!s_tready);
    sent++;
    @(negedge clk);
  endtask

  // reply side: stall modes of random length, plus one long hold-off
  initial begin
    int cyc;
    int hold_left;
    int mode;
    int mode_left;
    m_tready = 1'b0;
    cyc = 0;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (!rst) cyc++;
      if (cyc == HOLD_AT) hold_left = HOLD_LEN;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(10, 150);
        end
        mode_left--;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= ($urandom_range(0, 7) != 0);
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    burst_left = 0;
    sent = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill node 0, starting with a self link
    for (int t = 0; t < LINKS; t++)
      offer(link_req(0, t, t, VERTS - 1 - t, t[0] ? 32767 : -32768, t[0] ? 255 : 0));
    offer(link_req(0, NODES - 1, 0, 0, 0, 8'h5a));
    offer(link_req(0, LINKS - 1, VERTS - 1, 0, -1, 255));
    offer(link_req(-1, 5, 0, 0, 0, 0));
    offer(link_req(NODES, 5, 0, 0, 0, 0));
    offer(link_req(5, -32768, 1, 1, 0, 0));
    offer(link_req(5, 32767, 1, 1, 0, 0));
    offer(link_req(0, 3, VERTS, 0, 7, 7));
    offer(link_req(NODES - 1, 0, 0, -1, 7, 7));
    offer(link_req(NODES - 1, 0, -128, 127, 7, 7));
    offer(link_req(NODES - 1, NODES - 1, 0, 0, 1, 1));
    offer(link_req(NODES - 1, NODES - 1, 3, 4, 2, 2));

    repeat (RANDOM_REQS) offer(random_req());
    s_tvalid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (3 * (LINKS + 3)) @(posedge clk);

    $display("covered %0d requests: %0d inserts, %0d updates, %0d full,",
             sent, n_inserted, n_updated, n_full);
    $display("  %0d bad node, %0d bad edge; %0d mismatches, %0d replies still owed",
             n_bad_node, n_bad_edge, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("adjacency_link_table_upsert_top regression: pass");
    end else begin
      $display("adjacency_link_table_upsert_top regression: fail");
    end
    $finish;
  end

endmodule
